// ===== design/fips_pkg.sv =====
// ----------------------------------------------------------------------------
// fips_pkg
// Shared constants, codes and control structs of the flash image page stager.
// ----------------------------------------------------------------------------
package fips_pkg;

   localparam int PAGE_BYTES      = 256;
   localparam int SECTOR_BYTES    = 4096;
   localparam int ADDR_BITS       = 24;
   localparam int WORD_BYTES      = 8;

   localparam int PAGE_INDEX_BITS = $clog2(PAGE_BYTES);
   localparam int FILL_BITS       = PAGE_INDEX_BITS + 1;
   localparam int LANE_BITS       = $clog2(WORD_BYTES);
   localparam int PAGE_WORDS      = PAGE_BYTES / WORD_BYTES;
   localparam int WORD_INDEX_BITS = PAGE_INDEX_BITS - LANE_BITS;
   localparam int SECTOR_BITS     = $clog2(SECTOR_BYTES);

   localparam int KIND_BITS       = 2;
   localparam int BYTE_BITS       = 8;
   localparam int OP_BITS         = 2;
   localparam int OUT_ADDR_BITS   = 24;
   localparam int DATA_BITS       = 64;
   localparam int STATUS_BITS     = 2;
   localparam int CRC_BITS        = 32;
   localparam int COUNT_BITS      = 25;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CRC_BITS-1:0]      CRC_POLY       = 32'hEDB8_8320;
   localparam logic [CRC_BITS-1:0]      CRC_INIT       = 32'hFFFF_FFFF;
   localparam logic [BYTE_BITS-1:0]     PAD_BYTE       = 8'hFF;
   localparam logic [ADDR_BITS-1:0]     START_RESET    = ADDR_BITS'(20480);
   localparam logic [COUNT_BITS-1:0]    REGION_RESET   = COUNT_BITS'(2072576);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_BEGIN = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_ERASE   = 2'd0,
      OP_PROGRAM = 2'd1,
      OP_STATUS  = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_SIZE  = 2'd1,
      ST_SIZE_MISS = 2'd2,
      ST_CRC_MISS  = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_OFFSET  = 2'd0,
      CSR_REGION_BYTES  = 2'd1,
      CSR_EXPECTED_SIZE = 2'd2,
      CSR_EXPECTED_CRC  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                       wr_en;
      logic [PAGE_INDEX_BITS-1:0] wr_index;
      logic [BYTE_BITS-1:0]       wr_data;
      logic                       rd_en;
      logic [WORD_INDEX_BITS-1:0] rd_word;
   } buf_ctl_type;

   typedef struct packed {
      logic                 clear;
      logic                 update;
      logic [BYTE_BITS-1:0] data;
   } crc_ctl_type;

endpackage

// ===== design/fips_if.sv =====
// ----------------------------------------------------------------------------
// fips_if
// Valid/ready channels of the flash image page stager.
// ----------------------------------------------------------------------------
interface fips_req_if;
   logic                            valid;
   logic                            ready;
   logic [fips_pkg::KIND_BITS-1:0]  kind;
   logic [fips_pkg::BYTE_BITS-1:0]  data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface fips_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [fips_pkg::OP_BITS-1:0]       op;
   logic [fips_pkg::OUT_ADDR_BITS-1:0] flash_address;
   logic [fips_pkg::DATA_BITS-1:0]     program_data;
   logic [fips_pkg::STATUS_BITS-1:0]   status;
   logic [fips_pkg::CRC_BITS-1:0]      computed_crc;
   logic [fips_pkg::COUNT_BITS-1:0]    byte_count;
   logic                               last;

   modport source (output valid, op, flash_address, program_data, status,
                   computed_crc, byte_count, last, input ready);
   modport sink   (input valid, op, flash_address, program_data, status,
                   computed_crc, byte_count, last, output ready);
endinterface

interface fips_csr_if;
   logic                                valid;
   logic                                ready;
   logic [fips_pkg::CSR_INDEX_BITS-1:0] index;
   logic [fips_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/fips_page_buf.sv =====
// ----------------------------------------------------------------------------
// fips_page_buf
// Page memory: byte writes, registered word reads, 0xFF past the fill count.
// ----------------------------------------------------------------------------
module fips_page_buf (
   input  logic                                clock,
   input  fips_pkg::buf_ctl_type               ctl,
   input  logic [fips_pkg::FILL_BITS-1:0]      fill,
   output logic [fips_pkg::DATA_BITS-1:0]      rd_data
);
   import fips_pkg::*;

   logic [DATA_BITS-1:0]       mem [PAGE_WORDS];
   logic [DATA_BITS-1:0]       rd_word_data_ff;
   logic [WORD_INDEX_BITS-1:0] rd_word_ff;
   logic [WORD_INDEX_BITS-1:0] wr_word;
   logic [LANE_BITS-1:0]       wr_lane;

   assign wr_word = ctl.wr_index[PAGE_INDEX_BITS-1:LANE_BITS];
   assign wr_lane = ctl.wr_index[LANE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_word][{wr_lane, 3'b000} +: BYTE_BITS] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_word_data_ff <= mem[ctl.rd_word];
         rd_word_ff      <= ctl.rd_word;
      end
   end

   // pad lanes beyond the fill count
   always_comb begin
      logic [PAGE_INDEX_BITS-1:0] idx;
      for (int j = 0; j < WORD_BYTES; j++) begin
         idx = {rd_word_ff, LANE_BITS'(j)};
         if (FILL_BITS'(idx) < fill) begin
            rd_data[j*BYTE_BITS +: BYTE_BITS] = rd_word_data_ff[j*BYTE_BITS +: BYTE_BITS];
         end else begin
            rd_data[j*BYTE_BITS +: BYTE_BITS] = PAD_BYTE;
         end
      end
   end

endmodule

// ===== design/fips_crc_unit.sv =====
// ----------------------------------------------------------------------------
// fips_crc_unit
// Running reflected CRC-32, one byte per cycle.
// ----------------------------------------------------------------------------
module fips_crc_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  fips_pkg::crc_ctl_type             ctl,
   output logic [fips_pkg::CRC_BITS-1:0]     crc_value
);
   import fips_pkg::*;

   logic [CRC_BITS-1:0] crc_ff;
   logic [CRC_BITS-1:0] crc_in;
   logic [CRC_BITS-1:0] crc_step;

   always_comb begin
      logic [CRC_BITS-1:0] c;
      c = crc_ff ^ CRC_BITS'(ctl.data);
      for (int i = 0; i < BYTE_BITS; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_step = c;
   end

   always_comb begin
      priority if (ctl.clear) begin
         crc_in = CRC_INIT;
      end else if (ctl.update) begin
         crc_in = crc_step;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = ~crc_ff;

endmodule

// ===== design/flash_image_page_stager.sv =====
// ----------------------------------------------------------------------------
// flash_image_page_stager
// Stages an image body into flash pages and emits erase/program/status items.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one item per transfer: begin, data byte or end. csr_bus
//   writes the four setup registers (start offset, region size, expected
//   size, expected CRC) and is always ready; write it only while idle.
//   rsp_bus carries erase, program and status commands; last marks the final
//   command caused by one request.
// Sequence:
//   A data byte that does not fill the page is written while idle. A page
//   flush runs a setup state, an erase when the page starts a sector, and
//   then a page memory read and an output load per eight-byte program
//   command. End adds a status command. Requests wait while a flush runs.
// Reset:
//   Session state clears, the write address loads the start offset reset
//   value and the CRC register is all ones. Page memory is not cleared.
// Stall:
//   One output register holds a command until rsp_bus.ready; the erase,
//   program and status states hold while it is full and not being taken.
// ----------------------------------------------------------------------------
module flash_image_page_stager (
   input  logic      clock,
   input  logic      reset,
   fips_req_if.sink   req_bus,
   fips_rsp_if.source rsp_bus,
   fips_csr_if.sink   csr_bus
);
   import fips_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FLUSH,
      S_ERASE,
      S_READ,
      S_PROG,
      S_STATUS
   } state_type;

   state_type                  state_ff, state_in;
   logic [FILL_BITS-1:0]       fill_ff, fill_in;
   logic [ADDR_BITS-1:0]       addr_ff, addr_in;
   logic [COUNT_BITS-1:0]      committed_ff, committed_in;
   logic                       end_pend_ff, end_pend_in;
   logic [WORD_INDEX_BITS-1:0] word_ff, word_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   op_type                     rsp_op_ff, rsp_op_in;
   logic [OUT_ADDR_BITS-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [DATA_BITS-1:0]       rsp_data_ff, rsp_data_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic [CRC_BITS-1:0]        rsp_crc_ff, rsp_crc_in;
   logic [COUNT_BITS-1:0]      rsp_count_ff, rsp_count_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [ADDR_BITS-1:0]       start_ff;
   logic [COUNT_BITS-1:0]      region_ff;
   logic [COUNT_BITS-1:0]      exp_size_ff;
   logic [CRC_BITS-1:0]        exp_crc_ff;

   buf_ctl_type                buf_ctl;
   crc_ctl_type                crc_ctl;
   logic [DATA_BITS-1:0]       buf_rd_data;
   logic [CRC_BITS-1:0]        crc_value;

   logic                       req_fire;
   logic                       csr_fire;
   logic                       slot_free;
   logic                       last_word;
   logic [COUNT_BITS:0]        committed_sum;
   logic [ADDR_BITS-1:0]       prog_addr;
   status_type                 final_status;

   fips_page_buf u_page_buf (
      .clock   (clock),
      .ctl     (buf_ctl),
      .fill    (fill_ff),
      .rd_data (buf_rd_data)
   );

   fips_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (crc_ctl),
      .crc_value (crc_value)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign last_word     = (word_ff == WORD_INDEX_BITS'(PAGE_WORDS - 1));
   assign committed_sum = (COUNT_BITS+1)'(committed_ff) + (COUNT_BITS+1)'(fill_ff);
   assign prog_addr     = addr_ff + ADDR_BITS'({word_ff, {LANE_BITS{1'b0}}});

   always_comb begin
      priority if (exp_size_ff == '0 || exp_size_ff > region_ff) begin
         final_status = ST_BAD_SIZE;
      end else if (committed_ff != exp_size_ff) begin
         final_status = ST_SIZE_MISS;
      end else if (crc_value != exp_crc_ff) begin
         final_status = ST_CRC_MISS;
      end else begin
         final_status = ST_OK;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= START_RESET;
         region_ff   <= REGION_RESET;
         exp_size_ff <= '0;
         exp_crc_ff  <= '0;
      end else if (csr_fire) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_START_OFFSET:  start_ff    <= csr_bus.data[ADDR_BITS-1:0];
            CSR_REGION_BYTES:  region_ff   <= csr_bus.data[COUNT_BITS-1:0];
            CSR_EXPECTED_SIZE: exp_size_ff <= csr_bus.data[COUNT_BITS-1:0];
            CSR_EXPECTED_CRC:  exp_crc_ff  <= csr_bus.data[CRC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      addr_in       = addr_ff;
      committed_in  = committed_ff;
      end_pend_in   = end_pend_ff;
      word_in       = word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_op_in     = rsp_op_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_crc_in    = rsp_crc_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      buf_ctl          = '0;
      buf_ctl.wr_index = fill_ff[PAGE_INDEX_BITS-1:0];
      buf_ctl.wr_data  = req_bus.data_byte;
      buf_ctl.rd_word  = word_ff;
      crc_ctl          = '0;
      crc_ctl.data     = req_bus.data_byte;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (kind_type'(req_bus.kind))
                  KIND_BEGIN: begin
                     fill_in       = '0;
                     addr_in       = start_ff;
                     committed_in  = '0;
                     end_pend_in   = 1'b0;
                     crc_ctl.clear = 1'b1;
                  end
                  KIND_DATA: begin
                     crc_ctl.update = 1'b1;
                     buf_ctl.wr_en  = 1'b1;
                     fill_in        = fill_ff + 1'b1;
                     if (fill_ff == FILL_BITS'(PAGE_BYTES - 1)) begin
                        end_pend_in = 1'b0;
                        state_in    = S_FLUSH;
                     end
                  end
                  KIND_END: begin
                     end_pend_in = 1'b1;
                     state_in    = (fill_ff == '0) ? S_STATUS : S_FLUSH;
                  end
                  default: ;
               endcase
            end
         end
         S_FLUSH: begin
            committed_in = committed_sum[COUNT_BITS] ? '1 : committed_sum[COUNT_BITS-1:0];
            word_in      = '0;
            state_in     = (addr_ff[SECTOR_BITS-1:0] == '0) ? S_ERASE : S_READ;
         end
         S_ERASE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_op_in     = OP_ERASE;
               rsp_addr_in   = OUT_ADDR_BITS'(addr_ff);
               rsp_data_in   = '0;
               rsp_status_in = ST_OK;
               rsp_crc_in    = crc_value;
               rsp_count_in  = committed_ff;
               rsp_last_in   = 1'b0;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            buf_ctl.rd_en = 1'b1;
            state_in      = S_PROG;
         end
         S_PROG: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_op_in     = OP_PROGRAM;
               rsp_addr_in   = OUT_ADDR_BITS'(prog_addr);
               rsp_data_in   = buf_rd_data;
               rsp_status_in = ST_OK;
               rsp_crc_in    = crc_value;
               rsp_count_in  = committed_ff;
               rsp_last_in   = last_word && !end_pend_ff;
               word_in       = word_ff + 1'b1;
               if (last_word) begin
                  fill_in  = '0;
                  addr_in  = addr_ff + ADDR_BITS'(PAGE_BYTES);
                  state_in = end_pend_ff ? S_STATUS : S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_STATUS: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_op_in     = OP_STATUS;
               rsp_addr_in   = '0;
               rsp_data_in   = '0;
               rsp_status_in = final_status;
               rsp_crc_in    = crc_value;
               rsp_count_in  = committed_ff;
               rsp_last_in   = 1'b1;
               end_pend_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         addr_ff      <= START_RESET;
         committed_ff <= '0;
         end_pend_ff  <= 1'b0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         addr_ff      <= addr_in;
         committed_ff <= committed_in;
         end_pend_ff  <= end_pend_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_op_ff     <= rsp_op_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_crc_ff    <= rsp_crc_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.op            = rsp_op_ff;
   assign rsp_bus.flash_address = rsp_addr_ff;
   assign rsp_bus.program_data  = rsp_data_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.computed_crc  = rsp_crc_ff;
   assign rsp_bus.byte_count    = rsp_count_ff;
   assign rsp_bus.last          = rsp_last_ff;

   a_full_page_flush: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.kind == KIND_DATA && fill_ff == FILL_BITS'(PAGE_BYTES - 1))
      |=> (state_ff == S_FLUSH))
      else $error("full page did not start a flush");

   a_page_done_clears_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROG && slot_free && last_word) |=> (fill_ff == '0))
      else $error("fill count not cleared after page flush");

   a_erase_on_sector: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_op_ff == OP_ERASE)
      |-> (rsp_addr_ff[SECTOR_BITS-1:0] == '0))
      else $error("erase issued off a sector boundary");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STATUS && slot_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("status transfer not marked last");

   a_crc_stable_in_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && $past(state_ff != S_IDLE)) |-> $stable(crc_value))
      else $error("crc changed during flush");

endmodule
